FILE: rtl/lcma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcma_pkg: shared constants and types of the load cell moving average
// Default sizes, register indexes and reset values, and the sequencer states.
// ----------------------------------------------------------------------------
package lcma_pkg;

  localparam int DEPTH_DEFAULT       = 128;
  localparam int SAMPLE_BITS_DEFAULT = 12;

  localparam int GAIN_W     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GAIN = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4905;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_HOLD
  } state_e;

endpackage

FILE: rtl/lcma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcma_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lcma_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/lcma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcma_div: serial restoring divider
// Unsigned division, one quotient bit per cycle through one shared subtractor.
// ----------------------------------------------------------------------------
module lcma_div #(
  parameter int N = 28,
  parameter int D = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quotient_o
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     quo_q, quo_d;
  logic [D:0]       rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [D:0]       rem_sh;
  logic [D+1:0]     trial;

  always_comb begin
    rem_sh = {rem_q[D-1:0], quo_q[N-1]};
    trial  = {1'b0, rem_sh} - {2'b00, divisor_i};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(N);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // restore when the trial subtraction goes negative
      if (!trial[D+1]) begin
        rem_d = trial[D:0];
        quo_d = {quo_q[N-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[N-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/load_cell_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_moving_average: averaged weight from a load cell converter
// Offset and gain scaling, a ring of the last DEPTH weights with a running
// sum, and a serial division of the sum by the number of weights held.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  sample    in         sample_valid_i/stall_o  sample_code_i
//  result    out        result_valid_o/stall_i  average_weight_o, window_full_o
//  cfg       in         cfg_valid_i/ready_o     cfg_index_i, cfg_data_i
//
//  the result of each sample is set by the serial divider, one quotient bit per cycle
//  sample_stall_o is high from the transfer until the result is registered
//  the output register lets the next sample in while a result waits
//  reset clears the sum, pointer and fill count; the ring needs no clearing
// ----------------------------------------------------------------------------
module load_cell_moving_average #(
  parameter int DEPTH       = lcma_pkg::DEPTH_DEFAULT,
  parameter int SAMPLE_BITS = lcma_pkg::SAMPLE_BITS_DEFAULT,
  localparam int WEIGHT_W   = SAMPLE_BITS + 1 + lcma_pkg::GAIN_W - lcma_pkg::FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           sample_valid_i,
  output logic                           sample_stall_o,
  input  logic [SAMPLE_BITS-1:0]         sample_code_i,
  output logic                           result_valid_o,
  input  logic                           result_stall_i,
  output logic signed [WEIGHT_W-1:0]     average_weight_o,
  output logic                           window_full_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lcma_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lcma_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int GAIN_W = lcma_pkg::GAIN_W;
  localparam int FRAC   = lcma_pkg::FRAC_BITS;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + GAIN_W;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = WEIGHT_W + $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  lcma_pkg::state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0]     zero_q;
  logic [GAIN_W-1:0]          gain_q;
  logic [SAMPLE_BITS-1:0]     sample_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [WEIGHT_W-1:0] weight_q;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [ADDR_W-1:0]          ptr_q, ptr_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       neg_q;
  logic signed [WEIGHT_W-1:0] res_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [WEIGHT_W-1:0] avg_q;
  logic                       full_out_q;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W:0]     prod_full;
  logic signed [PROD_W-1:0]   prod_round;
  logic signed [WEIGHT_W-1:0] old_weight;
  logic                       full;
  logic                       ram_we;
  logic                       div_start, div_done;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           quotient;
  logic [WEIGHT_W-1:0]        quo_low;
  logic                       load_out;
  logic                       out_taken;

  assign full = (cnt_q == CNT_W'(DEPTH));

  // configuration, always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= '0;
      gain_q <= lcma_pkg::GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lcma_pkg::REG_ZERO_OFFSET: zero_q <= cfg_data_i[SAMPLE_BITS-1:0];
        lcma_pkg::REG_WEIGHT_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath arithmetic
  assign diff      = $signed({1'b0, sample_q}) - $signed({1'b0, zero_q});
  assign prod_full = diff * $signed({1'b0, gain_q});
  // bias negative products so the shift rounds toward zero
  assign prod_round = prod_q + $signed({{(PROD_W - FRAC){1'b0}}, {FRAC{prod_q[PROD_W-1]}}});
  assign sum_d = sum_q + SUM_W'(weight_q) - (full ? SUM_W'(old_weight) : SUM_W'(0));
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign quo_low = quotient[WEIGHT_W-1:0];

  lcma_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (weight_q),
    .raddr_i (ptr_q),
    .rdata_o (old_weight)
  );

  lcma_div #(
    .N (SUM_W),
    .D (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // sequencer
  assign out_taken = out_valid_q && !result_stall_i;

  always_comb begin
    state_d        = state_q;
    sample_stall_o = 1'b1;
    ram_we         = 1'b0;
    div_start      = 1'b0;
    load_out       = 1'b0;
    ptr_d          = ptr_q;
    cnt_d          = cnt_q;
    case (state_q)
      lcma_pkg::ST_IDLE: begin
        sample_stall_o = 1'b0;
        if (sample_valid_i) begin
          state_d = lcma_pkg::ST_MUL;
        end
      end
      lcma_pkg::ST_MUL:   state_d = lcma_pkg::ST_SCALE;
      lcma_pkg::ST_SCALE: state_d = lcma_pkg::ST_SUM;
      lcma_pkg::ST_SUM: begin
        ram_we = 1'b1;
        ptr_d  = (ptr_q == ADDR_W'(DEPTH - 1)) ? '0 : ptr_q + ADDR_W'(1);
        if (!full) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        state_d = lcma_pkg::ST_START;
      end
      lcma_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = lcma_pkg::ST_DIV;
      end
      lcma_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lcma_pkg::ST_HOLD;
        end
      end
      lcma_pkg::ST_HOLD: begin
        // wait for the output register to free up
        if (!out_valid_q || !result_stall_i) begin
          load_out = 1'b1;
          state_d  = lcma_pkg::ST_IDLE;
        end
      end
      default: state_d = lcma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_taken) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcma_pkg::ST_IDLE;
      sum_q       <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (state_q == lcma_pkg::ST_SUM) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lcma_pkg::ST_IDLE && sample_valid_i) begin
      sample_q <= sample_code_i;
    end
    if (state_q == lcma_pkg::ST_MUL) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
    if (state_q == lcma_pkg::ST_SCALE) begin
      weight_q <= prod_round[PROD_W-1:FRAC];
    end
    if (div_start) begin
      neg_q <= sum_q[SUM_W-1];
    end
    if (div_done) begin
      res_q <= neg_q ? $signed(-quo_low) : $signed(quo_low);
    end
    if (load_out) begin
      avg_q      <= res_q;
      full_out_q <= full;
    end
  end

  assign result_valid_o   = out_valid_q;
  assign average_weight_o = avg_q;
  assign window_full_o    = full_out_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the load cell moving average
// Drives converter samples and register writes, stalls the result side in
// random bursts, and compares every averaged weight with an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SAMPLE_W   = lcma_pkg::SAMPLE_BITS_DEFAULT;
  localparam int DEPTH      = lcma_pkg::DEPTH_DEFAULT;
  localparam int GAIN_W     = lcma_pkg::GAIN_W;
  localparam int FRAC_BITS  = lcma_pkg::FRAC_BITS;
  localparam int IDX_W      = lcma_pkg::CFG_IDX_W;
  localparam int DATA_W     = lcma_pkg::CFG_DATA_W;
  localparam int WEIGHT_W   = SAMPLE_W + 1 + GAIN_W - FRAC_BITS;

  localparam logic [SAMPLE_W-1:0] CODE_MAX = '1;
  localparam logic [IDX_W-1:0]    REG_SPARE_2 = 2'd2;
  localparam logic [IDX_W-1:0]    REG_SPARE_3 = 2'd3;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 204;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct {
    logic signed [WEIGHT_W-1:0] avg;
    logic                       full;
  } average_t;

  // running weight average, kept in step with every sample transfer
  class weight_scoreboard;
    logic [SAMPLE_W-1:0] zero_offset;
    logic [GAIN_W-1:0]   gain;
    longint              weights [DEPTH];
    longint              sum;
    int                  slot;
    int                  held;
    average_t            awaited [$];
    int                  errors;

    function new();
      zero_offset = '0;
      gain        = lcma_pkg::GAIN_RESET;
      sum         = 0;
      slot        = 0;
      held        = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        lcma_pkg::REG_ZERO_OFFSET: zero_offset = data[SAMPLE_W-1:0];
        lcma_pkg::REG_WEIGHT_GAIN: gain = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] code);
      longint   w;
      average_t r;
      // signed divide truncates toward zero on both sides
      w = ((longint'(code) - longint'(zero_offset)) * longint'(gain))
          / (longint'(1) << FRAC_BITS);
      // the oldest weight only drops out once the window is full
      if (held == DEPTH) sum -= weights[slot];
      else held++;
      weights[slot] = w;
      sum += w;
      slot = (slot + 1) % DEPTH;
      r.avg  = WEIGHT_W'(sum / held);
      r.full = (held == DEPTH);
      awaited.push_back(r);
    endfunction

    function void check_result(logic signed [WEIGHT_W-1:0] avg, logic full);
      average_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with none awaited, average_weight %0d window_full %0b",
                 $time, avg, full);
        return;
      end
      want = awaited.pop_front();
      if (avg !== want.avg) begin
        errors++;
        $display("%0t: average_weight expected %0d got %0d", $time, want.avg, avg);
      end
      if (full !== want.full) begin
        errors++;
        $display("%0t: window_full expected %0b got %0b", $time, want.full, full);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                       sample_valid_i;
  logic                       sample_stall_o;
  logic [SAMPLE_W-1:0]        sample_code_i;
  logic                       result_valid_o;
  logic                       result_stall_i;
  logic signed [WEIGHT_W-1:0] average_weight_o;
  logic                       window_full_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [IDX_W-1:0]           cfg_index_i;
  logic [DATA_W-1:0]          cfg_data_i;

  weight_scoreboard sb;
  int stall_pct   = 0;
  int idle_pct    = 0;
  int stuck_cycles = 0;

  load_cell_moving_average dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_valid_i  (sample_valid_i),
    .sample_stall_o  (sample_stall_o),
    .sample_code_i   (sample_code_i),
    .result_valid_o  (result_valid_o),
    .result_stall_i  (result_stall_i),
    .average_weight_o(average_weight_o),
    .window_full_o   (window_full_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // valid stays high on return so a back-to-back transfer can follow without a drop in valid
  task automatic send_sample(input logic [SAMPLE_W-1:0] code);
    sample_valid_i <= 1'b1;
    sample_code_i  <= code;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
    sb.note_sample(code);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // wait until every result is back and the divider has gone quiet
  task automatic settle();
    sample_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: random stall bursts at the rate of the current phase
  initial begin
    result_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        result_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        result_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && !result_stall_i)
      sb.check_result(average_weight_o, window_full_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (sample_valid_i && !sample_stall_o) ||
        (result_valid_o && !result_stall_i) || (cfg_valid_i && cfg_ready_o))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("load_cell_moving_average verification failed");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] offset;
    logic [GAIN_W-1:0]   gain;
    logic [SAMPLE_W-1:0] code;
    int                  pick;
    int                  near;

    sb = new();
    rst_ni         <= 1'b0;
    sample_valid_i <= 1'b0;
    sample_code_i  <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of offset and gain, no writes yet
    send_sample('0);
    send_sample(CODE_MAX);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'd1);
    send_sample(12'd2048);
    send_sample(12'd4094);
    settle();

    // top bits of the offset write are dropped; spare indexes must change nothing
    write_reg(lcma_pkg::REG_ZERO_OFFSET, 16'hF800);
    write_reg(lcma_pkg::REG_WEIGHT_GAIN, 16'h0001);
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h0000);
    cfg_valid_i <= 1'b0;
    // tiny gain: fractions round toward zero either side of the offset
    send_sample(12'd2048);
    send_sample(12'd2047);
    send_sample(12'd2049);
    send_sample('0);
    send_sample(CODE_MAX);
    send_sample(12'd1);
    settle();

    // largest negative weights
    write_reg(lcma_pkg::REG_ZERO_OFFSET, 16'h0FFF);
    write_reg(lcma_pkg::REG_WEIGHT_GAIN, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_sample('0);
    send_sample(CODE_MAX);
    send_sample(12'd4094);
    send_sample(12'd2048);
    send_sample('0);
    send_sample('0);
    send_sample(12'd1);
    send_sample(12'h7FF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          offset = 12'd2048;
          gain   = lcma_pkg::GAIN_RESET;
        end
        1: begin
          offset = '0;
          gain   = '1;
        end
        2: begin
          offset = CODE_MAX;
          gain   = '1;
        end
        3: begin
          offset = '0;
          gain   = '0;
        end
        default: begin
          offset = SAMPLE_W'($urandom_range(0, 4095));
          gain   = ($urandom_range(0, 1) != 0) ? GAIN_W'($urandom_range(0, 511))
                                               : GAIN_W'($urandom);
        end
      endcase
      write_reg(lcma_pkg::REG_ZERO_OFFSET, {4'($urandom), offset});
      write_reg(lcma_pkg::REG_WEIGHT_GAIN, gain);
      cfg_valid_i <= 1'b0;

      // every third phase runs flat out, the final one throughout
      if (p == NUM_PHASES - 1 || p % 3 == 1) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = ($urandom_range(0, 1) != 0) ? 10 : 35;
        stall_pct = ($urandom_range(0, 1) != 0) ? 5 : 20;
      end

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          code = pick[0] ? CODE_MAX : '0;
        end else if (pick < 35) begin
          // codes around the zero point exercise sign and rounding
          near = int'(offset) + int'($urandom_range(0, 16)) - 8;
          if (near < 0) near = 0;
          if (near > int'(CODE_MAX)) near = int'(CODE_MAX);
          code = SAMPLE_W'(near);
        end else begin
          code = SAMPLE_W'($urandom_range(0, 4095));
        end
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          sample_valid_i <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk_i);
        end
        send_sample(code);
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("load_cell_moving_average verification clean");
    end else begin
      $display("load_cell_moving_average verification failed");
    end
    $finish;
  end

endmodule
